// ===== sv/i2c_master_byte_engine_unit_macros.svh =====
// assertion macros used by the i2c master byte engine sequencer
`ifndef I2C_MASTER_BYTE_ENGINE_UNIT_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while in reset
`define MBE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2c engine check failed");

// next-cycle implication, disabled while in reset
`define MBE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2c engine check failed");

`else

`define MBE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define MBE_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/i2c_mbe_pkg.sv =====
// types and constants of the i2c master byte engine
package i2c_mbe_pkg;

    localparam int DELAY_W     = 16;
    localparam int BIT_IDX_W   = 4;
    localparam int IN_DATA_W   = 16;
    localparam int IN_USER_W   = 3;
    localparam int OUT_DATA_W  = 16;

    localparam logic [DELAY_W-1:0]   DELAY_RESET = 16'd240;
    localparam logic [BIT_IDX_W-1:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [2:0] {
        KIND_TICK  = 3'd0,
        KIND_START = 3'd1,
        KIND_STOP  = 3'd2,
        KIND_WRITE = 3'd3,
        KIND_READ  = 3'd4
    } kind_t;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'd0,
        PH_ST_A    = 5'd1,
        PH_ST_B    = 5'd2,
        PH_ST_C    = 5'd3,
        PH_SP_A    = 5'd4,
        PH_SP_B    = 5'd5,
        PH_W_HIGH  = 5'd6,
        PH_W_LOW   = 5'd7,
        PH_WA_HIGH = 5'd8,
        PH_WA_LOW  = 5'd9,
        PH_R_RISE  = 5'd10,
        PH_R_HOLD  = 5'd11,
        PH_R_LOW   = 5'd12,
        PH_RA_HIGH = 5'd13,
        PH_RA_LOW  = 5'd14
    } phase_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] byte_in;
        logic       ack_in;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       rejected;
        logic [7:0] read_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_release;
        logic       scl_release;
    } result_t;

endpackage

// ===== sv/i2c_mbe_in_reg.sv =====
// input register slice holding one command transaction
module i2c_mbe_in_reg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [i2c_mbe_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [i2c_mbe_pkg::IN_USER_W-1:0]  s_tuser,
    input  logic                               take,
    output logic                               item_valid,
    output i2c_mbe_pkg::item_t                 item
);
    import i2c_mbe_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.kind    <= s_tuser;
            item_reg.byte_in <= s_tdata[7:0];
            item_reg.ack_in  <= s_tdata[8];
            item_reg.sda_in  <= s_tdata[9];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== sv/i2c_mbe_seq.sv =====
// bus sequencer state and its one-tick next-state logic
`include "i2c_master_byte_engine_unit_macros.svh"

module i2c_mbe_seq (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             step_en,
    input  i2c_mbe_pkg::item_t               item,
    input  logic [i2c_mbe_pkg::DELAY_W-1:0]  delay_ticks,
    output i2c_mbe_pkg::result_t             result
);
    import i2c_mbe_pkg::*;

    phase_t               phase_reg,    phase_next;
    logic [BIT_IDX_W-1:0] bit_reg,      bit_next;
    logic [7:0]           shift_reg,    shift_next;
    logic [DELAY_W-1:0]   wait_reg,     wait_next;
    logic                 scl_reg,      scl_next;
    logic                 sda_reg,      sda_next;
    logic                 ack_mode_reg, ack_mode_next;
    logic [7:0]           last_reg,     last_next;

    logic [DELAY_W-1:0]   eff_delay;
    logic [DELAY_W-1:0]   wait_dec;
    logic [7:0]           shift_in;
    logic                 is_cmd;
    logic                 rej;
    logic                 done;

    assign eff_delay = (delay_ticks == '0) ? {{(DELAY_W-1){1'b0}}, 1'b1} : delay_ticks;
    assign wait_dec  = (wait_reg != '0) ? wait_reg - 1'b1 : wait_reg;
    assign shift_in  = {shift_reg[6:0], item.sda_in};
    assign is_cmd    = (item.kind == KIND_START) || (item.kind == KIND_STOP)
                    || (item.kind == KIND_WRITE) || (item.kind == KIND_READ);

    always_comb begin
        phase_next    = phase_reg;
        bit_next      = bit_reg;
        shift_next    = shift_reg;
        wait_next     = wait_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        ack_mode_next = ack_mode_reg;
        last_next     = last_reg;
        rej           = 1'b0;
        done          = 1'b0;

        if (phase_reg != PH_IDLE) begin
            rej       = is_cmd;
            wait_next = wait_dec;
            if (wait_dec == '0) begin
                case (phase_reg)
                    PH_ST_A: begin
                        sda_next   = 1'b0;
                        phase_next = PH_ST_B;
                        wait_next  = eff_delay;
                    end
                    PH_ST_B: begin
                        scl_next   = 1'b0;
                        phase_next = PH_ST_C;
                        wait_next  = eff_delay;
                    end
                    PH_SP_A: begin
                        sda_next   = 1'b1;
                        phase_next = PH_SP_B;
                        wait_next  = eff_delay;
                    end
                    PH_W_HIGH: begin
                        scl_next   = 1'b0;
                        bit_next   = bit_reg + 1'b1;
                        phase_next = PH_W_LOW;
                        wait_next  = eff_delay;
                    end
                    PH_W_LOW: begin
                        scl_next  = 1'b1;
                        wait_next = eff_delay;
                        if (bit_reg < BITS_PER_BYTE) begin
                            sda_next   = shift_reg[7];
                            shift_next = {shift_reg[6:0], 1'b0};
                            phase_next = PH_W_HIGH;
                        end else begin
                            sda_next   = 1'b1;
                            phase_next = PH_WA_HIGH;
                        end
                    end
                    PH_WA_HIGH: begin
                        scl_next   = 1'b0;
                        phase_next = PH_WA_LOW;
                        wait_next  = eff_delay;
                    end
                    PH_R_RISE: begin
                        shift_next = shift_in;
                        // a one-tick wait leaves no hold time: fall straight through
                        if (eff_delay == {{(DELAY_W-1){1'b0}}, 1'b1}) begin
                            scl_next   = 1'b0;
                            bit_next   = bit_reg + 1'b1;
                            phase_next = PH_R_LOW;
                            wait_next  = eff_delay;
                        end else begin
                            phase_next = PH_R_HOLD;
                            wait_next  = eff_delay - 1'b1;
                        end
                    end
                    PH_R_HOLD: begin
                        scl_next   = 1'b0;
                        bit_next   = bit_reg + 1'b1;
                        phase_next = PH_R_LOW;
                        wait_next  = eff_delay;
                    end
                    PH_R_LOW: begin
                        scl_next = 1'b1;
                        if (bit_reg < BITS_PER_BYTE) begin
                            phase_next = PH_R_RISE;
                            wait_next  = {{(DELAY_W-1){1'b0}}, 1'b1};
                        end else begin
                            last_next  = shift_reg;
                            sda_next   = !ack_mode_reg;
                            phase_next = PH_RA_HIGH;
                            wait_next  = eff_delay;
                        end
                    end
                    PH_RA_HIGH: begin
                        scl_next   = 1'b0;
                        phase_next = PH_RA_LOW;
                        wait_next  = eff_delay;
                    end
                    PH_RA_LOW: begin
                        sda_next   = 1'b1;
                        phase_next = PH_IDLE;
                        wait_next  = '0;
                        done       = 1'b1;
                    end
                    default: begin
                        phase_next = PH_IDLE;
                        wait_next  = '0;
                        done       = 1'b1;
                    end
                endcase
            end
        end else if (is_cmd) begin
            bit_next = '0;
            case (item.kind)
                KIND_START: begin
                    sda_next   = 1'b1;
                    scl_next   = 1'b1;
                    phase_next = PH_ST_A;
                    wait_next  = eff_delay;
                end
                KIND_STOP: begin
                    sda_next   = 1'b0;
                    scl_next   = 1'b1;
                    phase_next = PH_SP_A;
                    wait_next  = eff_delay;
                end
                KIND_WRITE: begin
                    sda_next   = item.byte_in[7];
                    shift_next = {item.byte_in[6:0], 1'b0};
                    scl_next   = 1'b1;
                    phase_next = PH_W_HIGH;
                    wait_next  = eff_delay;
                end
                default: begin
                    ack_mode_next = item.ack_in;
                    shift_next    = '0;
                    sda_next      = 1'b1;
                    scl_next      = 1'b1;
                    phase_next    = PH_R_RISE;
                    wait_next     = {{(DELAY_W-1){1'b0}}, 1'b1};
                end
            endcase
        end
    end

    always_comb begin
        result.scl_release = scl_next;
        result.sda_release = sda_next;
        result.busy_res    = (phase_next != PH_IDLE);
        result.done_res    = done;
        result.read_byte   = last_next;
        result.rejected    = rej;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            bit_reg      <= '0;
            shift_reg    <= '0;
            wait_reg     <= '0;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
            ack_mode_reg <= 1'b0;
            last_reg     <= '0;
        end else if (step_en) begin
            phase_reg    <= phase_next;
            bit_reg      <= bit_next;
            shift_reg    <= shift_next;
            wait_reg     <= wait_next;
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
            ack_mode_reg <= ack_mode_next;
            last_reg     <= last_next;
        end
    end

    // a running sequence always has a wait pending, idle has none
    `MBE_ASSERT_NOW(a_busy_wait, aclk, aresetn, phase_reg != PH_IDLE, wait_reg != '0)
    `MBE_ASSERT_NOW(a_idle_wait, aclk, aresetn, phase_reg == PH_IDLE, wait_reg == '0)
    // bit counter never runs past the ack bit
    `MBE_ASSERT_NOW(a_bit_range, aclk, aresetn, 1'b1, bit_reg <= BITS_PER_BYTE)
    // a finishing tick leaves the engine idle
    `MBE_ASSERT_NXT(a_done_idle, aclk, aresetn, step_en && done,
                    phase_reg == PH_IDLE && !$stable(phase_reg))
    // the sample tick after an scl release is a single-tick wait
    `MBE_ASSERT_NXT(a_rise_wait, aclk, aresetn, step_en && phase_next == PH_R_RISE,
                    wait_reg == {{(DELAY_W-1){1'b0}}, 1'b1})

endmodule

// ===== sv/i2c_mbe_out_reg.sv =====
// result register driving the master-side stream
module i2c_mbe_out_reg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                load,
    input  i2c_mbe_pkg::result_t                result,
    output logic                                free,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [i2c_mbe_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import i2c_mbe_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign free       = !valid_reg || m_tready;
    assign valid_next = free ? load : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (free && load) begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-$bits(result_t)){1'b0}}, data_reg};

endmodule

// ===== sv/i2c_master_byte_engine_unit.sv =====
// top level of the i2c master byte engine: command stream in, bus line levels out
//
// Open-drain I2C master sequencer advanced by one tick per input transaction. While idle
// a transaction may carry a command (start, stop, write byte, read byte); while a
// sequence runs, commands are rejected and flagged, and every transaction just counts
// the current bus wait down. Each wait lasts delay_ticks ticks (zero behaves as one) and
// a changed delay applies from the next bus phase. A write shifts the byte out MSB first
// and then clocks a released ack bit without sampling it; a read samples SDA on the
// first tick after each SCL rise and then drives ACK or NACK as requested. Every input
// transaction gives exactly one result transaction carrying the SCL/SDA release levels,
// busy, a done pulse, the last read byte and the rejected flag. Throughput is one
// transaction per clock while m_tready is high; a transaction passes the input register
// and then the result register, with the whole tick update done in the sequencer logic
// between them. Either side may stall freely: the input register keeps accepting while
// the result register is drained. delay_ticks is written over its own valid/ready
// channel, always ready, and must only be changed while no transaction is in flight.
module i2c_master_byte_engine_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // command stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [7:0] byte_in, [8] ack_in, [9] sda_in, [15:10] zero
    input  logic [i2c_mbe_pkg::IN_DATA_W-1:0]   s_tdata,
    // [2:0] kind
    input  logic [i2c_mbe_pkg::IN_USER_W-1:0]   s_tuser,
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] scl_release, [1] sda_release, [2] busy_res, [3] done_res,
    // [11:4] read_byte, [12] rejected, [15:13] zero
    output logic [i2c_mbe_pkg::OUT_DATA_W-1:0]  m_tdata,
    // delay register write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [i2c_mbe_pkg::DELAY_W-1:0]     cfg_data
);
    import i2c_mbe_pkg::*;

    logic               item_valid;
    item_t              item;
    logic               out_free;
    logic               step_en;
    result_t            result;
    logic [DELAY_W-1:0] delay_reg;

    // configuration is always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= DELAY_RESET;
        end else if (cfg_valid && cfg_ready) begin
            delay_reg <= cfg_data;
        end
    end

    // one tick is processed whenever a held item has a free result slot
    assign step_en = item_valid && out_free;

    i2c_mbe_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (step_en),
        .item_valid (item_valid),
        .item       (item)
    );

    i2c_mbe_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (step_en),
        .item        (item),
        .delay_ticks (delay_reg),
        .result      (result)
    );

    i2c_mbe_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step_en),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
